// ----- sv/ipdd_pkg.sv -----
package ipdd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int OUT_LEN_W           = 16;

    localparam logic [2:0] MARK_LEN = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [3:0] {
        PH_SEARCH  = 4'b0001,
        PH_DIGITS  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD    = 2'd0,
        KIND_NO_PAYLOAD = 2'd1,
        KIND_CUT_SHORT  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             payload_byte;
        logic                   payload_last;
        logic [OUT_LEN_W-1:0]   declared_length;
    } t_result;

    // Character expected at each position of the "+IPD," marker.
    function automatic logic [7:0] marker_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CH_PLUS;
            3'd1:    c = CH_I;
            3'd2:    c = CH_P;
            3'd3:    c = CH_D;
            3'd4:    c = CH_COMMA;
            default: c = CH_PLUS;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/ipd_response_deframer.sv -----
// An accepted item is held in the input register and is parsed while the result buffer is
// not full; its result, if any, is written into the result buffer and offered from there.
// Throughput: one item per cycle while the output is not stalled, set by the parser update and
// a two-entry result buffer that keeps the input open while one result waits.
// Reset (synchronous, active low) returns the parser to marker search and empties buffers.
module ipd_response_deframer
    import ipdd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_buffer_end,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_result_kind,
    output logic [7:0]           o_payload_byte,
    output logic                 o_payload_last,
    output logic [OUT_LEN_W-1:0] o_declared_length
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    t_result    r_slot0, r_slot1;
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    logic       full;
    logic       fire;
    logic       accept;
    logic       push;
    logic       pop;
    logic       res_valid;
    t_result    res;
    t_result    head;

    assign full    = (r_count == 2'd2);
    assign fire    = r_in_valid && !full;
    assign o_stall = r_in_valid && full;
    assign accept  = i_valid && !o_stall;

    ipdd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_data_byte    (r_in_byte),
        .i_buffer_end   (r_in_end),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    assign push = res_valid;
    assign pop  = (r_count != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_buffer_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && !r_wr_ptr) begin
            r_slot0 <= res;
        end
        if (push && r_wr_ptr) begin
            r_slot1 <= res;
        end
    end

    assign head              = r_rd_ptr ? r_slot1 : r_slot0;
    assign o_valid           = (r_count != 2'd0);
    assign o_result_kind     = head.kind;
    assign o_payload_byte    = head.payload_byte;
    assign o_payload_last    = head.payload_last;
    assign o_declared_length = head.declared_length;

endmodule

// ----- sv/ipdd_parser.sv -----
module ipdd_parser
    import ipdd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_buffer_end,
    output logic       o_result_valid,
    output t_result    o_result
);

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_match, n_match;
    logic [LENGTH_BITS-1:0] r_acc,   n_acc;
    logic [LENGTH_BITS-1:0] r_rem,   n_rem;

    logic [2:0]             pos;
    logic [2:0]             next_pos;
    logic [LENGTH_BITS+3:0] acc_wide;
    logic [LENGTH_BITS+3:0] acc_next;
    logic [3:0]             digit;
    logic                   emit;
    logic                   emit_last;
    logic                   delivered;

    always_comb begin
        n_phase   = r_phase;
        n_match   = r_match;
        n_acc     = r_acc;
        n_rem     = r_rem;
        emit      = 1'b0;
        emit_last = 1'b0;

        pos      = (r_match < MARK_LEN) ? r_match : 3'd0;
        next_pos = (i_data_byte == marker_char(pos)) ? pos + 3'd1 :
                   (i_data_byte == CH_PLUS) ? 3'd1 : 3'd0;

        // acc * 10 + digit, by shifts; wraps at the accumulator width.
        digit    = 4'(i_data_byte - CH_0);
        acc_wide = (LENGTH_BITS+4)'(r_acc);
        acc_next = (acc_wide << 3) + (acc_wide << 1) + (LENGTH_BITS+4)'(digit);

        case (r_phase)
            PH_SEARCH: begin
                if (i_data_byte == CH_NUL) begin
                    n_phase = PH_DONE;
                    n_match = 3'd0;
                end else if (next_pos == MARK_LEN) begin
                    n_phase = PH_DIGITS;
                    n_match = 3'd0;
                    n_acc   = '0;
                end else begin
                    n_match = next_pos;
                end
            end
            PH_DIGITS: begin
                if (i_data_byte inside {[CH_0:CH_9]}) begin
                    n_acc = acc_next[LENGTH_BITS-1:0];
                end else if (i_data_byte == CH_COLON && r_acc != '0) begin
                    n_phase = PH_PAYLOAD;
                    n_rem   = r_acc;
                end else begin
                    n_phase = PH_DONE;
                    n_match = 3'd0;
                end
            end
            PH_PAYLOAD: begin
                emit      = 1'b1;
                emit_last = (r_rem <= LENGTH_BITS'(1));
                if (emit_last) begin
                    n_rem   = '0;
                    n_phase = PH_DONE;
                    n_match = 3'd1;
                end else begin
                    n_rem = r_rem - LENGTH_BITS'(1);
                end
            end
            PH_DONE: begin
            end
            default: begin
                n_phase = PH_SEARCH;
            end
        endcase

        // In the finished phase a match position of one flags a full delivery.
        delivered = (n_phase == PH_DONE) && (n_match == 3'd1);

        o_result.payload_byte    = i_data_byte;
        o_result.payload_last    = emit_last;
        o_result.declared_length = OUT_LEN_W'(n_acc);
        o_result.kind            = KIND_PAYLOAD;
        o_result_valid           = 1'b0;
        if (emit) begin
            o_result_valid = i_fire;
            if (i_buffer_end && !emit_last) begin
                o_result.kind = KIND_CUT_SHORT;
            end
        end else if (i_buffer_end && !delivered) begin
            o_result_valid        = i_fire;
            o_result.kind         = KIND_NO_PAYLOAD;
            o_result.payload_byte = 8'h00;
        end

        // Every buffer starts from a clean state.
        if (i_buffer_end) begin
            n_phase = PH_SEARCH;
            n_match = 3'd0;
            n_acc   = '0;
            n_rem   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_match <= 3'd0;
            r_acc   <= '0;
            r_rem   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

endmodule
